>>> rtl/filtered_group_sum_aggregator_top_assert.svh
// Assertion macros for the filtered group-sum aggregator.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef FILTERED_GROUP_SUM_AGGREGATOR_TOP_ASSERT_SVH
`define FILTERED_GROUP_SUM_AGGREGATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FGSA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define FGSA_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("%m: forbidden condition seen");
`else
`define FGSA_ASSERT(name, clk, rst, prop)
`define FGSA_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

>>> rtl/fgsa_pkg.sv
// Package for the filtered group-sum aggregator: widths, codes and shared types.
// No dependencies; every module and interface of the block imports it.
package fgsa_pkg;

   localparam int REGION_W  = 8;
   localparam int NATION_W  = 5;
   localparam int YEAR_W    = 16;
   localparam int REVENUE_W = 32;
   localparam int SUM_W     = 64;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int NATION_BITS = 5;
   localparam int YEAR_BITS   = 3;
   localparam int KEY_BITS    = 2 * NATION_BITS + YEAR_BITS;
   localparam int GROUP_DEPTH = 1 << KEY_BITS;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [REGION_W-1:0] REGION_RESET     = 8'd0;
   localparam logic [YEAR_W-1:0]   FIRST_YEAR_RESET = 16'd1992;
   localparam logic [YEAR_W-1:0]   LAST_YEAR_RESET  = 16'd1997;

   localparam logic OP_ACCUM = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_YEAR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST_YEAR  = 2'd2;

   typedef struct packed {
      logic                 is_read;
      logic                 hit;
      logic [KEY_BITS-1:0]  slot;
      logic [REVENUE_W-1:0] revenue;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage

>>> rtl/fgsa_if.sv
// Channel interfaces for the filtered group-sum aggregator: request and response.
// Depends on fgsa_pkg for field widths.
interface fgsa_req_if;
   import fgsa_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [REGION_W-1:0]  cust_region;
   logic [REGION_W-1:0]  supp_region;
   logic [NATION_W-1:0]  cust_nation;
   logic [NATION_W-1:0]  supp_nation;
   logic [YEAR_W-1:0]    order_year;
   logic [REVENUE_W-1:0] revenue;

   modport source (
      output valid, opcode, cust_region, supp_region, cust_nation, supp_nation,
             order_year, revenue,
      input  ready
   );
   modport sink (
      input  valid, opcode, cust_region, supp_region, cust_nation, supp_nation,
             order_year, revenue,
      output ready
   );
endinterface

interface fgsa_rsp_if;
   import fgsa_pkg::*;

   logic             valid;
   logic             ready;
   logic             row_matched;
   logic             group_valid;
   logic [SUM_W-1:0] group_sum;

   modport source (
      output valid, row_matched, group_valid, group_sum,
      input  ready
   );
   modport sink (
      input  valid, row_matched, group_valid, group_sum,
      output ready
   );
endinterface

>>> rtl/filtered_group_sum_aggregator_top.sv
// Requests are queued, popped with a group-memory read and answered from the response register.
// The back end pops a new command only after the read-then-write for the last one is done.
// Reset is synchronous; afterwards a clearing pass zeroes every one of the 8192 group slots,
// during which no request is accepted while configuration writes are still taken.
// Top level of the filtered group-sum aggregator: front end, command queue, back end.
// Depends on fgsa_pkg, fgsa_if, fgsa_front, fgsa_queue and fgsa_back.
module filtered_group_sum_aggregator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [fgsa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fgsa_pkg::CSR_DATA_W-1:0] csr_wdata,
   fgsa_req_if.sink                        req_chan,
   fgsa_rsp_if.source                      rsp_chan
);
   import fgsa_pkg::*;

   cmd_type push_item;
   cmd_type pop_item;
   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   logic    clearing;

   fgsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .clearing  (clearing),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   fgsa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .empty     (q_empty)
   );

   fgsa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_item   (pop_item),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/fgsa_queue.sv
// Short command queue between the classifying front end and the group back end.
// Depends on fgsa_pkg and the assertion macro header.
`include "filtered_group_sum_aggregator_top_assert.svh"

module fgsa_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fgsa_pkg::cmd_type push_item,
   output logic             full,
   input  logic             pop,
   output fgsa_pkg::cmd_type pop_item,
   output logic             empty
);
   import fgsa_pkg::*;

   cmd_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;

   assign full     = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   `FGSA_ASSERT_NEVER(a_push_when_full, clock, reset, push && full)
   `FGSA_ASSERT_NEVER(a_pop_when_empty, clock, reset, pop && empty)
   `FGSA_ASSERT(a_count_bounded, clock, reset, count_ff <= (QPTR_BITS + 1)'(QUEUE_DEPTH))

endmodule

>>> rtl/fgsa_front.sv
// Front end: configuration registers, request handshake and row classification.
// Depends on fgsa_pkg and the fgsa_req_if interface.
module fgsa_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [fgsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fgsa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   fgsa_req_if.sink                           req_chan,
   input  logic                               clearing,
   input  logic                               q_full,
   output logic                               q_push,
   output fgsa_pkg::cmd_type                  q_item
);
   import fgsa_pkg::*;

   logic [REGION_W-1:0] region_ff;
   logic [YEAR_W-1:0]   first_year_ff;
   logic [YEAR_W-1:0]   last_year_ff;
   logic [YEAR_W-1:0]   year_off;
   logic                in_window;
   logic                row_pass;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff     <= REGION_RESET;
         first_year_ff <= FIRST_YEAR_RESET;
         last_year_ff  <= LAST_YEAR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REGION:     region_ff     <= csr_wdata[REGION_W-1:0];
            CSR_FIRST_YEAR: first_year_ff <= csr_wdata[YEAR_W-1:0];
            CSR_LAST_YEAR:  last_year_ff  <= csr_wdata[YEAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      year_off  = req_chan.order_year - first_year_ff;
      in_window = (req_chan.order_year >= first_year_ff) &&
                  (year_off[YEAR_W-1:YEAR_BITS] == '0);
      row_pass  = (req_chan.cust_region == region_ff) &&
                  (req_chan.supp_region == region_ff) &&
                  (req_chan.order_year <= last_year_ff) && in_window;
   end

   assign req_chan.ready = !clearing && !q_full;
   assign q_push         = req_chan.valid && req_chan.ready;

   always_comb begin
      q_item.is_read = (req_chan.opcode == OP_READ);
      q_item.hit     = (req_chan.opcode == OP_READ) ? in_window : row_pass;
      q_item.slot    = {req_chan.cust_nation[NATION_BITS-1:0],
                        req_chan.supp_nation[NATION_BITS-1:0],
                        year_off[YEAR_BITS-1:0]};
      q_item.revenue = req_chan.revenue;
   end

endmodule

>>> rtl/fgsa_back.sv
// Back end: group memory with clearing pass, read-modify-write and response register.
// Depends on fgsa_pkg, the fgsa_rsp_if interface and the assertion macro header.
`include "filtered_group_sum_aggregator_top_assert.svh"

module fgsa_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  fgsa_pkg::cmd_type q_item,
   output logic              q_pop,
   output logic              clearing,
   fgsa_rsp_if.source        rsp_chan
);
   import fgsa_pkg::*;

   back_state_type state_ff, state_in;
   logic [KEY_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   cmd_type             cmd_ff;

   logic [SUM_W:0]      mem [GROUP_DEPTH];
   logic [SUM_W:0]      rd_data_ff;
   logic                mem_rd_en;
   logic [KEY_BITS-1:0] mem_raddr;
   logic                mem_wr_en;
   logic [KEY_BITS-1:0] mem_waddr;
   logic [SUM_W:0]      mem_wdata;
   logic                rsp_load;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_matched_ff;
   logic             rsp_gvalid_ff;
   logic [SUM_W-1:0] rsp_sum_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            if (clr_cnt_ff == {KEY_BITS{1'b1}}) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (q_pop) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: state_in = BK_IDLE;
         default: state_in = BK_CLEAR;
      endcase
   end

   always_comb begin
      q_pop     = 1'b0;
      mem_rd_en = 1'b0;
      mem_raddr = q_item.slot;
      mem_wr_en = 1'b0;
      mem_waddr = cmd_ff.slot;
      mem_wdata = {1'b1, rd_data_ff[SUM_W-1:0] + {{(SUM_W - REVENUE_W){1'b0}}, cmd_ff.revenue}};
      rsp_load  = 1'b0;
      unique case (state_ff)
         BK_CLEAR: begin
            mem_wr_en = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
         end
         BK_IDLE: begin
            q_pop     = !q_empty && (!rsp_valid_ff || rsp_chan.ready);
            mem_rd_en = q_pop;
         end
         BK_EXEC: begin
            mem_wr_en = !cmd_ff.is_read && cmd_ff.hit;
            rsp_load  = 1'b1;
         end
         default: ;
      endcase
   end

   assign clearing   = (state_ff == BK_CLEAR);
   assign clr_cnt_in = clr_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_CLEAR) begin
            clr_cnt_ff <= clr_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_item;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_matched_ff <= !cmd_ff.is_read && cmd_ff.hit;
         rsp_gvalid_ff  <= cmd_ff.is_read && cmd_ff.hit && rd_data_ff[SUM_W];
         rsp_sum_ff     <= (cmd_ff.is_read && cmd_ff.hit) ? rd_data_ff[SUM_W-1:0] : '0;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.row_matched = rsp_matched_ff;
   assign rsp_chan.group_valid = rsp_gvalid_ff;
   assign rsp_chan.group_sum   = rsp_sum_ff;

   `FGSA_ASSERT(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == BK_EXEC)
   `FGSA_ASSERT(a_exec_slot_free, clock, reset, state_ff == BK_EXEC |-> !rsp_valid_ff)
   `FGSA_ASSERT_NEVER(a_pop_in_clear, clock, reset, clearing && q_pop)

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for filtered_group_sum_aggregator_top: directed rows and reads,
// then random phases under changing filter settings, checked against a group-sum scoreboard.
// Depends on fgsa_pkg, the fgsa_if channel interfaces and the top level of the block.
module tb_top;
   import fgsa_pkg::*;

   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PHASES   = 6;
   localparam int ROWS_PER_PHASE  = 180;

   typedef struct packed {
      logic                 opcode;
      logic [REGION_W-1:0]  cust_region;
      logic [REGION_W-1:0]  supp_region;
      logic [NATION_W-1:0]  cust_nation;
      logic [NATION_W-1:0]  supp_nation;
      logic [YEAR_W-1:0]    order_year;
      logic [REVENUE_W-1:0] revenue;
   } row_req_type;

   typedef struct packed {
      logic             row_matched;
      logic             group_valid;
      logic [SUM_W-1:0] group_sum;
   } group_rsp_type;

   class group_sum_scoreboard_type;
      logic [REGION_W-1:0] region_code;
      logic [YEAR_W-1:0]   first_year;
      logic [YEAR_W-1:0]   last_year;
      bit                  seen [GROUP_DEPTH];
      logic [SUM_W-1:0]    total [GROUP_DEPTH];
      group_rsp_type       awaited [$];
      int                  failures;

      function new();
         region_code = REGION_RESET;
         first_year  = FIRST_YEAR_RESET;
         last_year   = LAST_YEAR_RESET;
         failures    = 0;
         foreach (seen[i]) begin
            seen[i]  = 1'b0;
            total[i] = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_REGION:     region_code = data[REGION_W-1:0];
            CSR_FIRST_YEAR: first_year  = data[YEAR_W-1:0];
            CSR_LAST_YEAR:  last_year   = data[YEAR_W-1:0];
            default: ;
         endcase
      endfunction

      function bit find_slot(row_req_type r, output logic [KEY_BITS-1:0] slot);
         logic [YEAR_W-1:0] offset;
         offset = r.order_year - first_year;
         slot = {r.cust_nation[NATION_BITS-1:0], r.supp_nation[NATION_BITS-1:0],
                 offset[YEAR_BITS-1:0]};
         return (r.order_year >= first_year) && (offset < (1 << YEAR_BITS));
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= 10)
            $display("ERROR at %0t: %s", $time, msg);
      endfunction

      function void admit_request(row_req_type r);
         group_rsp_type       expected;
         logic [KEY_BITS-1:0] slot;
         bit                  in_window;
         expected  = '0;
         in_window = find_slot(r, slot);
         if (r.opcode == OP_ACCUM) begin
            if (r.cust_region == region_code && r.supp_region == region_code &&
                r.order_year <= last_year && in_window) begin
               seen[slot]  = 1'b1;
               total[slot] = total[slot] + SUM_W'(r.revenue);
               expected.row_matched = 1'b1;
            end
         end else if (in_window) begin
            expected.group_valid = seen[slot];
            expected.group_sum   = total[slot];
         end
         awaited.push_back(expected);
      endfunction

      function void check_result(group_rsp_type got);
         group_rsp_type expected;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected transaction: matched %0b valid %0b sum %h",
                             got.row_matched, got.group_valid, got.group_sum));
            return;
         end
         expected = awaited.pop_front();
         if (got.row_matched !== expected.row_matched ||
             got.group_valid !== expected.group_valid ||
             got.group_sum !== expected.group_sum)
            report($sformatf("expected matched %0b valid %0b sum %h, got %0b %0b %h",
                             expected.row_matched, expected.group_valid, expected.group_sum,
                             got.row_matched, got.group_valid, got.group_sum));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wr_en;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   bit                       idle_on = 1'b1;
   logic                     rsp_hold = 1'b0;
   logic [REGION_W-1:0]      cfg_region = REGION_RESET;
   logic [YEAR_W-1:0]        cfg_first = FIRST_YEAR_RESET;
   logic [YEAR_W-1:0]        cfg_last = LAST_YEAR_RESET;
   event                     hold_go;
   group_sum_scoreboard_type group_sums;

   fgsa_req_if req_bus ();
   fgsa_rsp_if rsp_bus ();

   filtered_group_sum_aggregator_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && csr_wr_en)
         group_sums.write_reg(csr_index, csr_wdata);
      if (!reset && req_bus.valid && req_bus.ready)
         group_sums.admit_request(row_req_type'{req_bus.opcode, req_bus.cust_region,
                                                req_bus.supp_region, req_bus.cust_nation,
                                                req_bus.supp_nation, req_bus.order_year,
                                                req_bus.revenue});
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         group_sums.check_result(group_rsp_type'{rsp_bus.row_matched, rsp_bus.group_valid,
                                                 rsp_bus.group_sum});
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // The receiver holds off long enough for the block to fill and stall its input.
   initial begin
      forever begin
         @(hold_go);
         rsp_hold <= 1'b1;
         repeat (HOLD_OFF_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   initial begin
      #1ms;
      $display("Some tests failed");
      $finish;
   end

   task automatic send_request(row_req_type r);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= r.opcode;
      req_bus.cust_region <= r.cust_region;
      req_bus.supp_region <= r.supp_region;
      req_bus.cust_nation <= r.cust_nation;
      req_bus.supp_nation <= r.supp_nation;
      req_bus.order_year  <= r.order_year;
      req_bus.revenue     <= r.revenue;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic send_fields(logic op, int cr, int sr, int cn, int sn, int yr,
                              logic [REVENUE_W-1:0] rev);
      send_request(row_req_type'{op, REGION_W'(cr), REGION_W'(sr), NATION_W'(cn),
                                 NATION_W'(sn), YEAR_W'(yr), rev});
   endtask

   task automatic finish_phase();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (group_sums.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic write_config(logic [REGION_W-1:0] region, logic [YEAR_W-1:0] first,
                               logic [YEAR_W-1:0] last);
      cfg_region = region;
      cfg_first  = first;
      cfg_last   = last;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_REGION;
      csr_wdata <= CSR_DATA_W'(region);
      @(posedge clock);
      csr_index <= CSR_FIRST_YEAR;
      csr_wdata <= first;
      @(posedge clock);
      csr_index <= CSR_LAST_YEAR;
      csr_wdata <= last;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_config();
      logic [REGION_W-1:0] region;
      logic [YEAR_W-1:0]   first;
      logic [YEAR_W-1:0]   last;
      case ($urandom_range(0, 3))
         0:       region = '0;
         1:       region = '1;
         default: region = REGION_W'($urandom);
      endcase
      case ($urandom_range(0, 4))
         0:       first = '0;
         1:       first = 16'hFFFF - YEAR_W'($urandom_range(0, 9));
         2:       first = FIRST_YEAR_RESET;
         default: first = YEAR_W'($urandom);
      endcase
      case ($urandom_range(0, 5))
         0:       last = first - 16'd1;
         1:       last = '1;
         default: last = (first > 16'hFFF0) ? 16'hFFFF : first + YEAR_W'($urandom_range(0, 12));
      endcase
      write_config(region, first, last);
   endtask

   function automatic row_req_type random_row();
      row_req_type r;
      r.opcode      = ($urandom_range(0, 9) < 3) ? OP_READ : OP_ACCUM;
      r.cust_region = ($urandom_range(0, 4) == 0) ? REGION_W'($urandom) : cfg_region;
      r.supp_region = ($urandom_range(0, 4) == 0) ? REGION_W'($urandom) : cfg_region;
      r.cust_nation = $urandom_range(0, 1) ? NATION_W'($urandom_range(0, 3)) : NATION_W'($urandom);
      r.supp_nation = $urandom_range(0, 1) ? NATION_W'($urandom_range(0, 3)) : NATION_W'($urandom);
      if ($urandom_range(0, 9) == 0)
         r.order_year = YEAR_W'($urandom);
      else
         r.order_year = cfg_first + YEAR_W'($urandom_range(0, 9));
      r.revenue = $urandom;
      return r;
   endfunction

   initial begin
      group_sums = new();
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_index           <= CSR_REGION;
      csr_wdata           <= '0;
      req_bus.valid       <= 1'b0;
      req_bus.opcode      <= OP_ACCUM;
      req_bus.cust_region <= '0;
      req_bus.supp_region <= '0;
      req_bus.cust_nation <= '0;
      req_bus.supp_nation <= '0;
      req_bus.order_year  <= '0;
      req_bus.revenue     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_fields(OP_ACCUM, 0, 0, 0, 0, 1992, 32'hFFFF_FFFF);
      send_fields(OP_ACCUM, 0, 0, 0, 0, 1992, 32'hFFFF_FFFF);
      send_fields(OP_READ, 0, 0, 0, 0, 1992, 32'h0);
      send_fields(OP_ACCUM, 0, 0, 31, 31, 1997, 32'h1);
      send_fields(OP_ACCUM, 0, 0, 31, 31, 1998, 32'h5);
      send_fields(OP_ACCUM, 0, 0, 31, 31, 1991, 32'h5);
      send_fields(OP_ACCUM, 1, 0, 2, 2, 1993, 32'h7);
      send_fields(OP_ACCUM, 0, 255, 2, 2, 1993, 32'h7);
      send_fields(OP_READ, 0, 0, 31, 31, 1997, 32'h0);
      send_fields(OP_READ, 0, 0, 31, 31, 1999, 32'h0);
      send_fields(OP_READ, 0, 0, 31, 31, 2000, 32'h0);
      send_fields(OP_READ, 0, 0, 0, 0, 0, 32'h0);
      send_fields(OP_READ, 255, 255, 31, 31, 65535, 32'hFFFF_FFFF);
      finish_phase();

      write_config(8'hFF, 16'd65528, 16'd65535);
      send_fields(OP_ACCUM, 255, 255, 31, 31, 65535, 32'hFFFF_FFFF);
      send_fields(OP_READ, 255, 255, 31, 31, 65535, 32'h0);
      send_fields(OP_READ, 0, 0, 0, 0, 65527, 32'h0);
      finish_phase();

      // A window wider than the year span is cut; old slots are seen at the new offsets.
      write_config(8'h80, 16'd100, 16'd65535);
      send_fields(OP_ACCUM, 128, 128, 3, 4, 107, 32'hA5A5_A5A5);
      send_fields(OP_ACCUM, 128, 128, 3, 4, 108, 32'h5A5A_5A5A);
      send_fields(OP_READ, 0, 0, 3, 4, 107, 32'h0);
      send_fields(OP_READ, 0, 0, 0, 0, 100, 32'h0);
      finish_phase();

      write_config(8'd7, 16'd500, 16'd499);
      send_fields(OP_ACCUM, 7, 7, 1, 1, 500, 32'h1234_5678);
      send_fields(OP_READ, 7, 7, 1, 1, 500, 32'h0);
      finish_phase();

      write_config(8'd0, 16'd0, 16'd0);
      send_fields(OP_ACCUM, 0, 0, 16, 16, 0, 32'h8000_0001);
      send_fields(OP_ACCUM, 0, 0, 16, 16, 1, 32'h8000_0001);
      send_fields(OP_READ, 0, 0, 16, 16, 0, 32'h0);
      finish_phase();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idle_on = !(p == 1 || p == RANDOM_PHASES - 1);
         random_config();
         if (p == 1)
            -> hold_go;
         repeat (ROWS_PER_PHASE) send_request(random_row());
         finish_phase();
      end

      repeat (6) @(posedge clock);
      if (group_sums.failures == 0 && group_sums.awaited.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/fgsa_pkg.sv
rtl/fgsa_if.sv
rtl/fgsa_queue.sv
rtl/fgsa_front.sv
rtl/fgsa_back.sv
rtl/filtered_group_sum_aggregator_top.sv
bench/tb_top.sv
